// File: design/trrs_pkg.sv
// Shared types, constants and helper functions for the three-class scheduler.
`default_nettype none

package trrs_pkg;

  localparam int NUM_AGENTS  = 256;
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_CLASSES = 3;

  localparam int AGENT_W = 8;
  localparam int AIDX_W  = $clog2(NUM_AGENTS);
  localparam int QAW     = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int QRAM_D  = NUM_CLASSES * QUEUE_DEPTH;
  localparam int QRAM_AW = $clog2(QRAM_D);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_STEP   = 2'd2,
    OP_BAD    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CLS_KERNEL = 2'd0,
    CLS_SYSTEM = 2'd1,
    CLS_NORMAL = 2'd2,
    CLS_NONE   = 2'd3
  } class_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ERR    = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_HALTED = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [AGENT_W-1:0]   agent_id;
    class_t               req_class;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [AGENT_W-1:0]   granted_agent;
    class_t               granted_class;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEM_RD,
    ST_MEM_CHK,
    ST_RM_RD,
    ST_RM_WR,
    ST_STEP_SEL,
    ST_STEP_RD,
    ST_STEP_WR,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_MEM_RD,
    DP_RES_OK,
    DP_ADD,
    DP_RM_INIT,
    DP_RM_RD,
    DP_RM_WR,
    DP_STEP_SEL,
    DP_STEP_RD,
    DP_STEP_WR,
    DP_RES_HALT,
    DP_RES_EMPTY,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    halted;
    logic    is_member;
    logic    add_ok;
    logic    step_found;
    logic    rm_last;
    logic    out_free;
  } ctl_stat_t;

  function automatic class_t next_class(input class_t c);
    class_t r;
    case (c)
      CLS_KERNEL: r = CLS_SYSTEM;
      CLS_SYSTEM: r = CLS_NORMAL;
      default:    r = CLS_KERNEL;
    endcase
    return r;
  endfunction

  // Position inside a circular queue: base plus offset, wrapped once.
  function automatic logic [QAW-1:0] qpos(input logic [QAW-1:0] base,
                                          input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return sum[QAW-1:0];
  endfunction

  function automatic logic [QRAM_AW-1:0] qaddr(input class_t c,
                                               input logic [QAW-1:0] pos);
    return QRAM_AW'(QRAM_AW'(c) * QRAM_AW'(QUEUE_DEPTH)) + QRAM_AW'(pos);
  endfunction

endpackage

`default_nettype wire

// File: design/three_class_round_robin_scheduler.sv
// Top level of the three-class round-robin scheduler.
//
// Input channel (in_valid / in_stall / in_data) carries one command per
// transaction: add an agent to a class queue, remove an agent, or step to
// grant the next agent. Every command yields exactly one result transaction
// on out_valid / out_stall / out_data with a status, and for a granting step
// the agent id and the class it came from.
// Commands are worked one at a time by a controller and a datapath around
// two registered-read RAMs (queue entries and agent class tags).
// Add and remove first read the agent's class tag and check membership; a remove
// of a member then scans its queue, reading each entry and writing back the ones
// that stay. A step selects a class, reads the queue head and appends it at the
// tail; a halted or empty step and an invalid opcode go straight to the result.
// in_stall drops on the edge that loads the result register, so the next
// command is accepted only after the previous result has been loaded.
// If the receiver stalls with a result held and another is ready, the block
// holds in_stall high until the output register frees.
// cfg_wr_en / cfg_wr_data set the halt bit; write it only while idle.
// Synchronous reset empties all queues, marks every agent unqueued, points
// the turn at the normal class and clears the halt bit; no clearing pass.
`default_nettype none

module three_class_round_robin_scheduler (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire trrs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output trrs_pkg::out_item_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data
);

  trrs_pkg::dp_cmd_t   cmd;
  trrs_pkg::ctl_stat_t stat;

  trrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  trrs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

// File: design/trrs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module trrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/trrs_ctrl.sv
// Controller state machine that sequences the scheduler datapath.
`default_nettype none

module trrs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire trrs_pkg::opcode_t   in_opcode,
  output logic                     in_stall,
  input  wire trrs_pkg::ctl_stat_t stat,
  output trrs_pkg::dp_cmd_t        cmd
);

  trrs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            trrs_pkg::OP_ADD:    state_nxt = trrs_pkg::ST_MEM_RD;
            trrs_pkg::OP_REMOVE: state_nxt = trrs_pkg::ST_MEM_RD;
            trrs_pkg::OP_STEP:   state_nxt = trrs_pkg::ST_STEP_SEL;
            default:             state_nxt = trrs_pkg::ST_DONE;
          endcase
        end
      end
      trrs_pkg::ST_MEM_RD: state_nxt = trrs_pkg::ST_MEM_CHK;
      trrs_pkg::ST_MEM_CHK: begin
        if (stat.opcode == trrs_pkg::OP_REMOVE && stat.is_member) begin
          state_nxt = trrs_pkg::ST_RM_RD;
        end else begin
          state_nxt = trrs_pkg::ST_DONE;
        end
      end
      trrs_pkg::ST_RM_RD: state_nxt = trrs_pkg::ST_RM_WR;
      trrs_pkg::ST_RM_WR: begin
        state_nxt = stat.rm_last ? trrs_pkg::ST_DONE : trrs_pkg::ST_RM_RD;
      end
      trrs_pkg::ST_STEP_SEL: begin
        if (!stat.halted && stat.step_found) begin
          state_nxt = trrs_pkg::ST_STEP_RD;
        end else begin
          state_nxt = trrs_pkg::ST_DONE;
        end
      end
      trrs_pkg::ST_STEP_RD: state_nxt = trrs_pkg::ST_STEP_WR;
      trrs_pkg::ST_STEP_WR: state_nxt = trrs_pkg::ST_DONE;
      trrs_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = trrs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != trrs_pkg::ST_IDLE);
    cmd.op   = trrs_pkg::DP_NOP;
    case (state_r)
      trrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op = trrs_pkg::DP_LATCH;
        end
      end
      trrs_pkg::ST_MEM_RD: cmd.op = trrs_pkg::DP_MEM_RD;
      trrs_pkg::ST_MEM_CHK: begin
        if (stat.opcode == trrs_pkg::OP_ADD) begin
          if (stat.is_member) begin
            cmd.op = trrs_pkg::DP_RES_OK;
          end else if (stat.add_ok) begin
            cmd.op = trrs_pkg::DP_ADD;
          end
        end else if (stat.is_member) begin
          cmd.op = trrs_pkg::DP_RM_INIT;
        end
      end
      trrs_pkg::ST_RM_RD: cmd.op = trrs_pkg::DP_RM_RD;
      trrs_pkg::ST_RM_WR: cmd.op = trrs_pkg::DP_RM_WR;
      trrs_pkg::ST_STEP_SEL: begin
        if (stat.halted) begin
          cmd.op = trrs_pkg::DP_RES_HALT;
        end else if (stat.step_found) begin
          cmd.op = trrs_pkg::DP_STEP_SEL;
        end else begin
          cmd.op = trrs_pkg::DP_RES_EMPTY;
        end
      end
      trrs_pkg::ST_STEP_RD: cmd.op = trrs_pkg::DP_STEP_RD;
      trrs_pkg::ST_STEP_WR: cmd.op = trrs_pkg::DP_STEP_WR;
      trrs_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.op = trrs_pkg::DP_OUT_LOAD;
        end
      end
      default: cmd.op = trrs_pkg::DP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: design/trrs_datapath.sv
// Scheduler datapath: queue and membership memories, counters, pointers, result registers.
`default_nettype none

module trrs_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire trrs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output trrs_pkg::out_item_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data,
  input  wire trrs_pkg::dp_cmd_t   cmd,
  output trrs_pkg::ctl_stat_t      stat
);

  logic                                halted_r, halted_nxt;
  trrs_pkg::opcode_t                   op_r, op_nxt;
  logic [trrs_pkg::AGENT_W-1:0]        agent_r, agent_nxt;
  trrs_pkg::class_t                    cls_r, cls_nxt;
  trrs_pkg::class_t                    cur_r, cur_nxt;
  trrs_pkg::class_t                    turn_r, turn_nxt;
  logic [trrs_pkg::CW-1:0]             cnt_r [trrs_pkg::NUM_CLASSES];
  logic [trrs_pkg::CW-1:0]             cnt_nxt [trrs_pkg::NUM_CLASSES];
  logic [trrs_pkg::QAW-1:0]            head_r [trrs_pkg::NUM_CLASSES];
  logic [trrs_pkg::QAW-1:0]            head_nxt [trrs_pkg::NUM_CLASSES];
  logic [trrs_pkg::CW-1:0]             scan_i_r, scan_i_nxt;
  logic [trrs_pkg::CW-1:0]             scan_j_r, scan_j_nxt;
  trrs_pkg::out_item_t                 res_r, res_nxt;
  trrs_pkg::out_item_t                 out_r, out_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [trrs_pkg::NUM_AGENTS-1:0]     mvalid_r, mvalid_nxt;

  logic                                q_we, q_re;
  logic [trrs_pkg::QRAM_AW-1:0]        q_waddr, q_raddr;
  logic [trrs_pkg::AGENT_W-1:0]        q_wdata, q_rdata;
  logic                                m_we, m_re;
  logic [1:0]                          m_rdata;

  trrs_pkg::class_t                    mclass, cls_idx, widx;
  trrs_pkg::class_t                    t1, t2, chosen;
  logic                                found;
  logic [trrs_pkg::CW-1:0]             cnt_sel;
  logic [trrs_pkg::QAW-1:0]            head_sel, tail_pos, scan_pos, keep_pos;
  logic                                keep;
  logic                                rm_last;

  trrs_ram #(
    .WIDTH (trrs_pkg::AGENT_W),
    .DEPTH (trrs_pkg::QRAM_D)
  ) u_qram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_en   (q_re),
    .rd_addr (q_raddr),
    .rd_data (q_rdata)
  );

  trrs_ram #(
    .WIDTH (2),
    .DEPTH (trrs_pkg::NUM_AGENTS)
  ) u_mram (
    .clk     (clk),
    .wr_en   (m_we),
    .wr_addr (agent_r[trrs_pkg::AIDX_W-1:0]),
    .wr_data (cls_r),
    .rd_en   (m_re),
    .rd_addr (agent_r[trrs_pkg::AIDX_W-1:0]),
    .rd_data (m_rdata)
  );

  // An agent whose valid bit is clear reads as not queued.
  assign mclass  = mvalid_r[agent_r[trrs_pkg::AIDX_W-1:0]] ? trrs_pkg::class_t'(m_rdata)
                                                            : trrs_pkg::CLS_NONE;
  assign cls_idx = (cls_r == trrs_pkg::CLS_NONE) ? trrs_pkg::CLS_KERNEL : cls_r;
  assign widx    = (op_r == trrs_pkg::OP_ADD) ? cls_idx : cur_r;

  assign cnt_sel  = cnt_r[widx];
  assign head_sel = head_r[widx];
  assign tail_pos = trrs_pkg::qpos(head_sel, cnt_sel);
  assign scan_pos = trrs_pkg::qpos(head_sel, scan_i_r);
  assign keep_pos = trrs_pkg::qpos(head_sel, scan_j_r);
  assign keep     = (q_rdata != agent_r);
  assign rm_last  = (trrs_pkg::CW'(scan_i_r + trrs_pkg::CW'(1)) == cnt_sel);

  // The turn moves before each look, so the search order starts after turn_r.
  assign t1 = trrs_pkg::next_class(turn_r);
  assign t2 = trrs_pkg::next_class(t1);

  always_comb begin
    found  = 1'b1;
    chosen = t1;
    if (cnt_r[t1] != '0) begin
      chosen = t1;
    end else if (cnt_r[t2] != '0) begin
      chosen = t2;
    end else if (cnt_r[turn_r] != '0) begin
      chosen = turn_r;
    end else begin
      found = 1'b0;
    end
  end

  assign stat.opcode     = op_r;
  assign stat.halted     = halted_r;
  assign stat.is_member  = (mclass != trrs_pkg::CLS_NONE);
  assign stat.add_ok     = (cls_r != trrs_pkg::CLS_NONE) &&
                           (cnt_sel != trrs_pkg::CW'(trrs_pkg::QUEUE_DEPTH));
  assign stat.step_found = found;
  assign stat.rm_last    = rm_last;
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    halted_nxt    = cfg_wr_en ? cfg_wr_data : halted_r;
    op_nxt        = op_r;
    agent_nxt     = agent_r;
    cls_nxt       = cls_r;
    cur_nxt       = cur_r;
    turn_nxt      = turn_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    scan_i_nxt    = scan_i_r;
    scan_j_nxt    = scan_j_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mvalid_nxt    = mvalid_r;
    q_we          = 1'b0;
    q_re          = 1'b0;
    q_waddr       = trrs_pkg::qaddr(widx, tail_pos);
    q_raddr       = trrs_pkg::qaddr(widx, head_sel);
    q_wdata       = q_rdata;
    m_we          = 1'b0;
    m_re          = 1'b0;

    case (cmd.op)
      trrs_pkg::DP_LATCH: begin
        op_nxt    = in_data.opcode;
        agent_nxt = in_data.agent_id;
        cls_nxt   = in_data.req_class;
        res_nxt   = '{status: trrs_pkg::STAT_ERR, granted_agent: '0,
                      granted_class: trrs_pkg::CLS_KERNEL};
      end
      trrs_pkg::DP_MEM_RD: begin
        m_re = 1'b1;
      end
      trrs_pkg::DP_RES_OK: begin
        res_nxt.status = trrs_pkg::STAT_OK;
      end
      trrs_pkg::DP_ADD: begin
        q_we           = 1'b1;
        q_wdata        = agent_r;
        cnt_nxt[widx]  = trrs_pkg::CW'(cnt_sel + trrs_pkg::CW'(1));
        m_we           = 1'b1;
        mvalid_nxt[agent_r[trrs_pkg::AIDX_W-1:0]] = 1'b1;
        res_nxt.status = trrs_pkg::STAT_OK;
      end
      trrs_pkg::DP_RM_INIT: begin
        cur_nxt    = mclass;
        scan_i_nxt = '0;
        scan_j_nxt = '0;
        mvalid_nxt[agent_r[trrs_pkg::AIDX_W-1:0]] = 1'b0;
      end
      trrs_pkg::DP_RM_RD: begin
        q_re    = 1'b1;
        q_raddr = trrs_pkg::qaddr(widx, scan_pos);
      end
      trrs_pkg::DP_RM_WR: begin
        // Survivors are packed toward the head; writes never pass the read point.
        q_waddr    = trrs_pkg::qaddr(widx, keep_pos);
        q_we       = keep;
        scan_i_nxt = trrs_pkg::CW'(scan_i_r + trrs_pkg::CW'(1));
        if (keep) begin
          scan_j_nxt = trrs_pkg::CW'(scan_j_r + trrs_pkg::CW'(1));
        end
        if (rm_last) begin
          cnt_nxt[widx]  = keep ? trrs_pkg::CW'(scan_j_r + trrs_pkg::CW'(1)) : scan_j_r;
          res_nxt.status = trrs_pkg::STAT_OK;
        end
      end
      trrs_pkg::DP_STEP_SEL: begin
        turn_nxt = chosen;
        cur_nxt  = chosen;
      end
      trrs_pkg::DP_STEP_RD: begin
        q_re = 1'b1;
      end
      trrs_pkg::DP_STEP_WR: begin
        // Rotate: the head moves on and its entry is appended at the tail.
        q_we           = 1'b1;
        head_nxt[widx] = trrs_pkg::qpos(head_sel, trrs_pkg::CW'(1));
        res_nxt        = '{status: trrs_pkg::STAT_OK, granted_agent: q_rdata,
                           granted_class: cur_r};
      end
      trrs_pkg::DP_RES_HALT: begin
        res_nxt.status = trrs_pkg::STAT_HALTED;
      end
      trrs_pkg::DP_RES_EMPTY: begin
        res_nxt.status = trrs_pkg::STAT_EMPTY;
      end
      trrs_pkg::DP_OUT_LOAD: begin
        out_nxt       = res_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r    <= 1'b0;
      turn_r      <= trrs_pkg::CLS_NORMAL;
      cnt_r       <= '{default: '0};
      head_r      <= '{default: '0};
      out_valid_r <= 1'b0;
      mvalid_r    <= '0;
    end else begin
      halted_r    <= halted_nxt;
      turn_r      <= turn_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      mvalid_r    <= mvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    agent_r  <= agent_nxt;
    cls_r    <= cls_nxt;
    cur_r    <= cur_nxt;
    scan_i_r <= scan_i_nxt;
    scan_j_r <= scan_j_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: design/trrs_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none

module trrs_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire trrs_pkg::out_item_t out_data
);

  // A held result must not move while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Only a granting step carries an agent and class.
  a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != trrs_pkg::STAT_OK |->
      out_data.granted_agent == '0 && out_data.granted_class == trrs_pkg::CLS_KERNEL)
    else $error("grant fields set on a non-ok result");

  // Commands are worked one at a time: the block is busy right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a command was still in work");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind three_class_round_robin_scheduler trrs_checker u_trrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
